### rtl/prrts_pkg.sv
// Shared types, constants and helper functions of the task scheduler.
package prrts_pkg;

   localparam int TASK_SLOTS      = 16;
   localparam int PRIORITY_LEVELS = 8;
   localparam int TICK_BITS       = 32;

   localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
   localparam int COUNT_BITS = $clog2(TASK_SLOTS + 1);
   localparam int PRIO_BITS  = $clog2(PRIORITY_LEVELS);

   localparam logic [COUNT_BITS-1:0] IDLE_ID = COUNT_BITS'(TASK_SLOTS);

   typedef enum logic [2:0] {
      FN_CREATE  = 3'd0,
      FN_YIELD   = 3'd1,
      FN_DELAY   = 3'd2,
      FN_UNTIL   = 3'd3,
      FN_SWEEP   = 3'd4,
      FN_SET     = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_RUNNING = 2'd1,
      ST_BLOCKED = 2'd2
   } run_state_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_FULL   = 2'd1,
      STS_PRIO   = 2'd2,
      STS_PASSED = 2'd3
   } status_type;

   // One row of the task table.
   typedef struct packed {
      logic [1:0]           run_state;
      logic [PRIO_BITS-1:0] prio;
      logic [TICK_BITS-1:0] wake_tick;
      logic                 object_wait;
   } entry_type;

   // Write port of the task table.
   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      entry_type            data;
   } table_wr_type;

   // True when a - b, read as a signed tick difference, is at most zero.
   function automatic logic tick_reached(input logic [TICK_BITS-1:0] a,
                                         input logic [TICK_BITS-1:0] b);
      logic [TICK_BITS-1:0] d;
      d = a - b;
      return (d == '0) || d[TICK_BITS-1];
   endfunction

endpackage

### rtl/prrts_table.sv
// Task table memory: one write port and one registered read port.
module prrts_table (
   input  logic                           clock,
   input  prrts_pkg::table_wr_type        wr,
   input  logic                           rd_en,
   input  logic [prrts_pkg::SLOT_BITS-1:0] rd_addr,
   output prrts_pkg::entry_type           rd_data
);
   import prrts_pkg::*;

   entry_type mem [TASK_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/priority_round_robin_task_scheduler.sv
// Top level of the fixed-priority round-robin task scheduler.
// The task table lives in a single-port-read memory, and yield, delay and sweep requests walk
// it one entry per cycle. A create, rejected or ignored request goes straight to the result; a
// set-state request does one read-modify-write of the table; a yield or delay does at most a
// read-modify-write of the running task, a pass to find the highest ready priority, a
// round-robin pass at that level and a commit read-modify-write; a wakeup sweep walks the
// table. The result is held until the receiver stops stalling, and the next request is taken
// once it has gone. Task slot 16 stands for the idle task.
module priority_round_robin_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_priority_req,
   input  logic [31:0] req_tick_now,
   input  logic [31:0] req_delay_ticks,
   input  logic [31:0] req_target_tick,
   input  logic [3:0]  req_task_index,
   input  logic [1:0]  req_new_state,
   input  logic        req_waits_on_object,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_chosen_task,
   output logic        rsp_switched,
   output logic [4:0]  rsp_woken_count,
   output logic [31:0] rsp_spurious_total,
   output logic [3:0]  rsp_created_index
);
   import prrts_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN, S_OUT} state_type;
   typedef enum logic [1:0] {K_SET, K_YIELD, K_BLOCK, K_COMMIT} kind_type;
   typedef enum logic [1:0] {PH_MAX, PH_RR, PH_SWEEP} phase_type;

   state_type             state_ff;
   kind_type              kind_ff;
   phase_type             phase_ff;
   logic [2:0]            func_ff;
   logic [TICK_BITS-1:0]  now_ff;
   logic [TICK_BITS-1:0]  wake_val_ff;
   logic [1:0]            nst_ff;
   logic                  wob_ff;
   logic [SLOT_BITS-1:0]  addr_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic [COUNT_BITS-1:0] running_ff;
   logic [COUNT_BITS-1:0] cursor_ff [PRIORITY_LEVELS];
   logic [31:0]           supp_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [SLOT_BITS-1:0]  rd_idx_ff;
   logic                  ev_ff;
   logic [SLOT_BITS-1:0]  ev_idx_ff;
   logic                  found_ff;
   logic [PRIO_BITS-1:0]  best_ff;
   logic [SLOT_BITS-1:0]  pick_ff;
   logic [1:0]            status_ff;
   logic                  sw_ff;
   logic [4:0]            woken_ff;
   logic [3:0]            created_ff;

   table_wr_type          wr;
   logic                  rd_en;
   logic [SLOT_BITS-1:0]  rd_addr;
   entry_type             rd_data;
   entry_type             mod_entry;
   logic                  scan_done;
   logic                  running_valid;
   logic                  sweep_hit;
   logic [COUNT_BITS-1:0] rd_idx_inc;
   logic [COUNT_BITS-1:0] cur_sel;
   logic [COUNT_BITS-1:0] cur_inc;
   logic [SLOT_BITS-1:0]  rr_start;
   logic [COUNT_BITS-1:0] nt;
   logic [TICK_BITS-1:0]  req_tick;
   logic [TICK_BITS-1:0]  req_target;

   prrts_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tick      = req_tick_now[TICK_BITS-1:0];
   assign req_target    = req_target_tick[TICK_BITS-1:0];
   assign running_valid = running_ff < n_ff;
   assign scan_done     = (rd_cnt_ff == n_ff) && !ev_ff;
   assign rd_idx_inc    = COUNT_BITS'(rd_idx_ff) + 1'b1;
   assign cur_sel       = cursor_ff[best_ff];
   assign cur_inc       = cur_sel + 1'b1;
   assign rr_start      = (cur_inc < n_ff) ? cur_inc[SLOT_BITS-1:0] : '0;
   assign nt            = (phase_ff == PH_RR) ? COUNT_BITS'(pick_ff) : IDLE_ID;
   assign sweep_hit     = ev_ff && (phase_ff == PH_SWEEP)
                          && (rd_data.run_state == ST_BLOCKED)
                          && tick_reached(rd_data.wake_tick, now_ff);

   always_comb begin
      mod_entry = rd_data;
      case (kind_ff)
         K_SET: begin
            mod_entry.run_state   = nst_ff;
            mod_entry.object_wait = wob_ff;
         end
         K_YIELD: mod_entry.run_state = ST_READY;
         K_BLOCK: begin
            mod_entry.run_state   = ST_BLOCKED;
            mod_entry.wake_tick   = wake_val_ff;
            mod_entry.object_wait = 1'b0;
         end
         K_COMMIT: mod_entry.run_state = ST_RUNNING;
         default: mod_entry = rd_data;
      endcase
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff;
      wr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_func == FN_CREATE && n_ff < IDLE_ID
                && req_priority_req < 8'(PRIORITY_LEVELS)) begin
               wr.en                  = 1'b1;
               wr.addr                = n_ff[SLOT_BITS-1:0];
               wr.data.run_state      = ST_READY;
               wr.data.prio           = req_priority_req[PRIO_BITS-1:0];
               wr.data.wake_tick      = '0;
               wr.data.object_wait    = 1'b0;
            end
         end
         S_RMW_RD: begin
            rd_en   = 1'b1;
            rd_addr = addr_ff;
         end
         S_RMW_WR: begin
            wr.en   = 1'b1;
            wr.addr = addr_ff;
            wr.data = mod_entry;
         end
         S_SCAN: begin
            rd_en = rd_cnt_ff < n_ff;
            if (sweep_hit && !rd_data.object_wait) begin
               wr.en                = 1'b1;
               wr.addr              = ev_idx_ff;
               wr.data              = rd_data;
               wr.data.run_state    = ST_READY;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         n_ff       <= '0;
         running_ff <= IDLE_ID;
         supp_ff    <= '0;
         ev_ff      <= 1'b0;
         rd_cnt_ff  <= '0;
         for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            cursor_ff[p] <= IDLE_ID;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff     <= req_func;
                  now_ff      <= req_tick;
                  wake_val_ff <= (req_func == FN_DELAY)
                                 ? req_tick + req_delay_ticks[TICK_BITS-1:0] : req_target;
                  nst_ff      <= req_new_state;
                  wob_ff      <= req_waits_on_object;
                  status_ff   <= STS_OK;
                  sw_ff       <= 1'b0;
                  woken_ff    <= '0;
                  created_ff  <= '0;
                  rd_cnt_ff   <= '0;
                  rd_idx_ff   <= '0;
                  ev_ff       <= 1'b0;
                  found_ff    <= 1'b0;
                  best_ff     <= '0;
                  state_ff    <= S_OUT;
                  case (req_func)
                     FN_CREATE: begin
                        if (n_ff >= IDLE_ID) begin
                           status_ff <= STS_FULL;
                        end else if (req_priority_req >= 8'(PRIORITY_LEVELS)) begin
                           status_ff <= STS_PRIO;
                        end else begin
                           created_ff <= 4'(n_ff);
                           n_ff       <= n_ff + 1'b1;
                        end
                     end
                     FN_YIELD: begin
                        phase_ff <= PH_MAX;
                        addr_ff  <= running_ff[SLOT_BITS-1:0];
                        kind_ff  <= K_YIELD;
                        state_ff <= running_valid ? S_RMW_RD : S_SCAN;
                     end
                     FN_DELAY, FN_UNTIL: begin
                        phase_ff <= PH_MAX;
                        addr_ff  <= running_ff[SLOT_BITS-1:0];
                        kind_ff  <= K_BLOCK;
                        if (req_func == FN_UNTIL && tick_reached(req_target, req_tick)) begin
                           status_ff <= STS_PASSED;
                        end else begin
                           state_ff <= running_valid ? S_RMW_RD : S_SCAN;
                        end
                     end
                     FN_SWEEP: begin
                        phase_ff <= PH_SWEEP;
                        state_ff <= S_SCAN;
                     end
                     FN_SET: begin
                        addr_ff <= req_task_index[SLOT_BITS-1:0];
                        kind_ff <= K_SET;
                        if (COUNT_BITS'(req_task_index) < n_ff
                            && req_new_state <= ST_BLOCKED) begin
                           state_ff <= S_RMW_RD;
                        end
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RMW_RD: state_ff <= S_RMW_WR;
            S_RMW_WR: begin
               state_ff <= (kind_ff == K_YIELD || kind_ff == K_BLOCK) ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
               if (rd_cnt_ff < n_ff) begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
                  rd_idx_ff <= (rd_idx_inc == n_ff) ? '0 : rd_idx_inc[SLOT_BITS-1:0];
               end
               ev_ff     <= rd_cnt_ff < n_ff;
               ev_idx_ff <= rd_idx_ff;
               if (ev_ff) begin
                  case (phase_ff)
                     PH_MAX: begin
                        if (rd_data.run_state == ST_READY
                            && (!found_ff || rd_data.prio > best_ff)) begin
                           found_ff <= 1'b1;
                           best_ff  <= rd_data.prio;
                        end
                     end
                     PH_RR: begin
                        // The first ready task at the best level after the cursor wins.
                        if (!found_ff && rd_data.run_state == ST_READY
                            && rd_data.prio == best_ff) begin
                           found_ff <= 1'b1;
                           pick_ff  <= ev_idx_ff;
                        end
                     end
                     default: begin
                        if (sweep_hit) begin
                           if (rd_data.object_wait) begin
                              supp_ff <= supp_ff + 1'b1;
                           end else begin
                              woken_ff <= woken_ff + 1'b1;
                           end
                        end
                     end
                  endcase
               end
               if (scan_done) begin
                  if (phase_ff == PH_MAX && found_ff) begin
                     phase_ff  <= PH_RR;
                     found_ff  <= 1'b0;
                     rd_cnt_ff <= '0;
                     rd_idx_ff <= rr_start;
                  end else if (phase_ff == PH_SWEEP) begin
                     state_ff <= S_OUT;
                  end else begin
                     if (phase_ff == PH_RR) begin
                        cursor_ff[best_ff] <= nt;
                     end
                     running_ff <= nt;
                     sw_ff      <= (func_ff == FN_YIELD) ? (nt != running_ff) : 1'b1;
                     addr_ff    <= nt[SLOT_BITS-1:0];
                     kind_ff    <= K_COMMIT;
                     state_ff   <= (nt != IDLE_ID) ? S_RMW_RD : S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall          = state_ff != S_IDLE;
   assign rsp_valid          = state_ff == S_OUT;
   assign rsp_status         = status_ff;
   assign rsp_chosen_task    = 5'(running_ff);
   assign rsp_switched       = sw_ff;
   assign rsp_woken_count    = woken_ff;
   assign rsp_spurious_total = supp_ff;
   assign rsp_created_index  = created_ff;

endmodule
